/* rtl/bgd_pkg.sv */
`timescale 1ns / 1ps

package bgd_pkg;

	localparam int CFG_W = 16;

	// gesture codes as reported on the result channel
	typedef enum logic [2:0] {
		GEST_NONE   = 3'd0,
		GEST_CLICK  = 3'd1,
		GEST_DOUBLE = 3'd2,
		GEST_HELD   = 3'd3,
		GEST_LONG   = 3'd4
	} gesture_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_REFRESH = 2'd0,
		CFG_DOUBLE  = 2'd1,
		CFG_HOLD    = 2'd2,
		CFG_LONG    = 2'd3
	} cfg_idx_t;

	// timer slots
	localparam int TMR_REFRESH = 0;
	localparam int TMR_DOUBLE  = 1;
	localparam int TMR_HOLD    = 2;
	localparam int TMR_LONG    = 3;
	localparam int NUM_TMR     = 4;

	localparam logic [CFG_W-1:0] RST_REFRESH = 16'd10;
	localparam logic [CFG_W-1:0] RST_DOUBLE  = 16'd300;
	localparam logic [CFG_W-1:0] RST_HOLD    = 16'd1000;
	localparam logic [CFG_W-1:0] RST_LONG    = 16'd3000;

endpackage

/* rtl/button_gesture_detector_top.sv */
`timescale 1ns / 1ps

// A result is registered in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; the whole tick update is a short
// combinational path on timer and flag registers; the output register refills while draining.
// Reset (arst_n low, asynchronous): timers and flags clear, position reads released,
// intervals return to 10 / 300 / 1000 / 3000 ticks, output register empties.
module button_gesture_detector_top #(
	parameter int TIMER_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [bgd_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      level_high,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                gesture,
	output logic                      pressed
);

	localparam int CMP_W = (TIMER_BITS > bgd_pkg::CFG_W) ? TIMER_BITS : bgd_pkg::CFG_W;

	logic [bgd_pkg::CFG_W-1:0] interval_q [bgd_pkg::NUM_TMR];
	logic [TIMER_BITS-1:0]     elapsed_q  [bgd_pkg::NUM_TMR];
	logic [TIMER_BITS-1:0]     inc        [bgd_pkg::NUM_TMR];
	logic [TIMER_BITS-1:0]     elapsed_d  [bgd_pkg::NUM_TMR];
	logic                      pass       [bgd_pkg::NUM_TMR];

	logic sampled_pressed_q, wait_double_q, wait_hold_q, wait_long_hold_q, just_doubled_q;
	logic sampled_d, wait_double_d, wait_hold_d, wait_long_hold_d, just_doubled_d;
	bgd_pkg::gesture_t gesture_d, gesture_q;
	logic pressed_q, out_valid_q;
	logic in_accept;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign pressed   = pressed_q;

	// saturating advance and interval check per timer
	always_comb begin
		for (int i = 0; i < bgd_pkg::NUM_TMR; i++) begin
			inc[i]  = (elapsed_q[i] == {TIMER_BITS{1'b1}}) ? elapsed_q[i]
				: elapsed_q[i] + 1'b1;
			pass[i] = CMP_W'(inc[i]) >= CMP_W'(interval_q[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < bgd_pkg::NUM_TMR; i++) begin
			elapsed_d[i] = inc[i];
		end
		sampled_d        = sampled_pressed_q;
		wait_double_d    = wait_double_q;
		wait_hold_d      = wait_hold_q;
		wait_long_hold_d = wait_long_hold_q;
		just_doubled_d   = just_doubled_q;
		gesture_d        = bgd_pkg::GEST_NONE;

		if (pass[bgd_pkg::TMR_REFRESH]) begin
			elapsed_d[bgd_pkg::TMR_REFRESH] = '0;
			sampled_d = ~level_high;
		end

		if (!sampled_d) begin
			if (!sampled_pressed_q) begin
				// window expiry while released
				if (wait_double_q && pass[bgd_pkg::TMR_DOUBLE]) begin
					elapsed_d[bgd_pkg::TMR_DOUBLE] = '0;
					gesture_d      = bgd_pkg::GEST_CLICK;
					wait_double_d  = 1'b0;
					just_doubled_d = 1'b0;
				end
			end else begin
				// release: open the double-click window if the hold is still awaited and no double just completed
				if (wait_hold_q && !just_doubled_q) begin
					elapsed_d[bgd_pkg::TMR_DOUBLE] = '0;
					wait_double_d = 1'b1;
				end
				just_doubled_d   = 1'b0;
				wait_hold_d      = 1'b0;
				wait_long_hold_d = 1'b0;
			end
		end else begin
			if (!sampled_pressed_q) begin
				if (wait_double_q) begin
					if (pass[bgd_pkg::TMR_DOUBLE]) begin
						// late re-press: click and reopen the window
						elapsed_d[bgd_pkg::TMR_DOUBLE] = '0;
						gesture_d      = bgd_pkg::GEST_CLICK;
						just_doubled_d = 1'b0;
					end else begin
						gesture_d      = bgd_pkg::GEST_DOUBLE;
						just_doubled_d = 1'b1;
						wait_double_d  = 1'b0;
					end
				end else begin
					elapsed_d[bgd_pkg::TMR_HOLD] = '0;
					elapsed_d[bgd_pkg::TMR_LONG] = '0;
					wait_hold_d      = 1'b1;
					wait_long_hold_d = 1'b1;
				end
			end else if (!just_doubled_q) begin
				if (wait_hold_q && pass[bgd_pkg::TMR_HOLD]) begin
					elapsed_d[bgd_pkg::TMR_HOLD] = '0;
					gesture_d   = bgd_pkg::GEST_HELD;
					wait_hold_d = 1'b0;
				end else if (wait_long_hold_q && pass[bgd_pkg::TMR_LONG]) begin
					elapsed_d[bgd_pkg::TMR_LONG] = '0;
					gesture_d        = bgd_pkg::GEST_LONG;
					wait_long_hold_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q[bgd_pkg::TMR_REFRESH] <= bgd_pkg::RST_REFRESH;
			interval_q[bgd_pkg::TMR_DOUBLE]  <= bgd_pkg::RST_DOUBLE;
			interval_q[bgd_pkg::TMR_HOLD]    <= bgd_pkg::RST_HOLD;
			interval_q[bgd_pkg::TMR_LONG]    <= bgd_pkg::RST_LONG;
		end else if (cfg_we) begin
			case (bgd_pkg::cfg_idx_t'(cfg_index))
				bgd_pkg::CFG_REFRESH: interval_q[bgd_pkg::TMR_REFRESH] <= cfg_data;
				bgd_pkg::CFG_DOUBLE:  interval_q[bgd_pkg::TMR_DOUBLE]  <= cfg_data;
				bgd_pkg::CFG_HOLD:    interval_q[bgd_pkg::TMR_HOLD]    <= cfg_data;
				bgd_pkg::CFG_LONG:    interval_q[bgd_pkg::TMR_LONG]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bgd_pkg::NUM_TMR; i++) begin
				elapsed_q[i] <= '0;
			end
			sampled_pressed_q <= 1'b0;
			wait_double_q     <= 1'b0;
			wait_hold_q       <= 1'b0;
			wait_long_hold_q  <= 1'b0;
			just_doubled_q    <= 1'b0;
		end else if (in_accept) begin
			for (int i = 0; i < bgd_pkg::NUM_TMR; i++) begin
				elapsed_q[i] <= elapsed_d[i];
			end
			sampled_pressed_q <= sampled_d;
			wait_double_q     <= wait_double_d;
			wait_hold_q       <= wait_hold_d;
			wait_long_hold_q  <= wait_long_hold_d;
			just_doubled_q    <= just_doubled_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			gesture_q <= gesture_d;
			pressed_q <= sampled_d;
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid)
		else $error("accepted item did not reach the output register");

	a_double_marks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (gesture_q != bgd_pkg::GEST_DOUBLE || just_doubled_q))
		else $error("double click reported without just-doubled flag");

	a_held_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (gesture_q != bgd_pkg::GEST_HELD || !wait_hold_q))
		else $error("held reported while hold still awaited");

	a_hold_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> ((gesture_q != bgd_pkg::GEST_HELD && gesture_q != bgd_pkg::GEST_LONG)
			|| pressed_q))
		else $error("hold gesture reported while released");

endmodule
